FILE: src/sync_flag_length_deframer_assert.svh
// assertion macros for the sync flag length deframer
// expects i_clk and i_rst_n in the scope where a macro is used
`ifndef SYNC_FLAG_LENGTH_DEFRAMER_ASSERT_SVH
`define SYNC_FLAG_LENGTH_DEFRAMER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SFLD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SFLD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/sfld_pkg.sv
// shared types and constants for the sync flag length deframer
// no dependencies
`timescale 1ns / 1ps

package sfld_pkg;

    localparam logic [7:0] SYNC_BYTE = 8'h2f;
    localparam int unsigned HDR_LEN = 8;

    // result kinds
    localparam logic [1:0] KIND_HDR_OK  = 2'd0;
    localparam logic [1:0] KIND_BODY    = 2'd1;
    localparam logic [1:0] KIND_HDR_BAD = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2
    } t_phase;

    // decoded header fields
    typedef struct packed {
        logic signed [7:0]  category;
        logic signed [15:0] msg_id;
        logic signed [31:0] total_length;
        logic               ok;
        logic [30:0]        body_len;
    } t_hdr_info;

    // one result item
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [7:0]  category;
        logic signed [15:0] msg_id;
        logic signed [31:0] total_length;
        logic [15:0]        skipped_count;
        logic [7:0]         body_byte;
        logic               last;
    } t_result;

endpackage

FILE: src/sfld_hdr_decode.sv
// header field assembly and validity check
// depends on sfld_pkg
`timescale 1ns / 1ps

module sfld_hdr_decode (
    input  logic [5:0][7:0]      i_hdr,
    input  logic [7:0]           i_last_byte,
    input  logic                 i_big_endian,
    output sfld_pkg::t_hdr_info  o_info
);
    import sfld_pkg::*;

    logic [15:0] id_raw;
    logic [31:0] len_raw;

    // byte order selection
    always_comb begin
        if (i_big_endian) begin
            id_raw  = {i_hdr[1], i_hdr[2]};
            len_raw = {i_hdr[3], i_hdr[4], i_hdr[5], i_last_byte};
        end else begin
            id_raw  = {i_hdr[2], i_hdr[1]};
            len_raw = {i_last_byte, i_hdr[5], i_hdr[4], i_hdr[3]};
        end
    end

    // fields, check and body length
    always_comb begin
        o_info.category     = $signed(i_hdr[0]);
        o_info.msg_id       = $signed(id_raw);
        o_info.total_length = $signed(len_raw);
        o_info.ok           = (i_hdr[0] != 8'd0) && !i_hdr[0][7] &&
                              (id_raw != 16'd0) && !id_raw[15] &&
                              !len_raw[31] && (len_raw[30:3] != 28'd0);
        o_info.body_len     = len_raw[30:0] - 31'(HDR_LEN);
    end

endmodule

FILE: src/sfld_ctrl.sv
// frame state machine: hunt, header gather, body pass-through
// depends on sfld_pkg and sfld_hdr_decode
`timescale 1ns / 1ps

module sfld_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  logic              i_accept,
    input  logic [7:0]        i_in_byte,
    output logic              o_res_valid,
    output sfld_pkg::t_result o_res
);
    import sfld_pkg::*;

    t_phase          r_phase, n_phase;
    logic [2:0]      r_hdr_idx, n_hdr_idx;
    logic [5:0][7:0] r_hdr, n_hdr;
    logic [30:0]     r_body_rem, n_body_rem;
    logic [15:0]     r_skip, n_skip;
    logic            r_big_endian;
    logic            hdr_done;
    logic            body_end;
    t_hdr_info       info;

    sfld_hdr_decode u_decode (
        .i_hdr        (r_hdr),
        .i_last_byte  (i_in_byte),
        .i_big_endian (r_big_endian),
        .o_info       (info)
    );

    assign hdr_done = (r_hdr_idx == 3'd6);
    assign body_end = (r_body_rem <= 31'd1);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_accept) begin
            case (r_phase)
                PH_HEADER: begin
                    if (hdr_done) begin
                        n_phase = (info.ok && (info.body_len != 31'd0)) ? PH_BODY : PH_HUNT;
                    end
                end
                PH_BODY: begin
                    if (body_end) begin
                        n_phase = PH_HUNT;
                    end
                end
                default: begin
                    n_phase = (i_in_byte == SYNC_BYTE) ? PH_HEADER : PH_HUNT;
                end
            endcase
        end
    end

    // result for the transfer being taken
    always_comb begin
        o_res_valid = 1'b0;
        o_res       = '0;
        case (r_phase)
            PH_HEADER: begin
                o_res_valid         = i_accept && hdr_done;
                o_res.kind          = info.ok ? KIND_HDR_OK : KIND_HDR_BAD;
                o_res.category      = info.category;
                o_res.msg_id        = info.msg_id;
                o_res.total_length  = info.total_length;
                o_res.skipped_count = r_skip;
                o_res.last          = !info.ok || (info.body_len == 31'd0);
            end
            PH_BODY: begin
                o_res_valid     = i_accept;
                o_res.kind      = KIND_BODY;
                o_res.body_byte = i_in_byte;
                o_res.last      = body_end;
            end
            default: begin
                o_res_valid = 1'b0;
            end
        endcase
    end

    // data state
    always_comb begin
        n_hdr_idx  = r_hdr_idx;
        n_hdr      = r_hdr;
        n_body_rem = r_body_rem;
        n_skip     = r_skip;
        if (i_accept) begin
            case (r_phase)
                PH_HEADER: begin
                    if (hdr_done) begin
                        n_hdr_idx  = 3'd0;
                        n_skip     = 16'd0;
                        n_body_rem = info.ok ? info.body_len : r_body_rem;
                    end else begin
                        n_hdr[r_hdr_idx] = i_in_byte;
                        n_hdr_idx        = r_hdr_idx + 3'd1;
                    end
                end
                PH_BODY: begin
                    n_body_rem = body_end ? 31'd0 : r_body_rem - 31'd1;
                end
                default: begin
                    if (i_in_byte == SYNC_BYTE) begin
                        n_hdr_idx = 3'd0;
                    end else if (r_skip != 16'hffff) begin
                        n_skip = r_skip + 16'd1;
                    end
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_hdr_idx    <= 3'd0;
            r_body_rem   <= 31'd0;
            r_skip       <= 16'd0;
            r_big_endian <= 1'b0;
        end else begin
            r_phase    <= n_phase;
            r_hdr_idx  <= n_hdr_idx;
            r_body_rem <= n_body_rem;
            r_skip     <= n_skip;
            if (i_cfg_wr_en) begin
                r_big_endian <= i_cfg_wr_data;
            end
        end
    end

    // header byte store, always written before it is read
    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

endmodule

FILE: src/sfld_out_reg.sv
// result register between the state machine and the output channel
// depends on sfld_pkg
`timescale 1ns / 1ps

module sfld_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  sfld_pkg::t_result i_res,
    input  logic              i_stall,
    output logic              o_full_stall,
    output logic              o_valid,
    output sfld_pkg::t_result o_res
);
    import sfld_pkg::*;

    logic    r_valid;
    t_result r_res;

    // upstream must wait only while a result is held and not taken
    assign o_full_stall = r_valid && i_stall;
    assign o_valid      = r_valid;
    assign o_res        = r_res;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

FILE: src/sync_flag_length_deframer.sv
// top level of the sync flag length deframer
// depends on sfld_pkg, sfld_ctrl, sfld_out_reg and the assertion header
`timescale 1ns / 1ps
//
// Byte-serial deframer. Input channel: i_valid / i_in_byte, with o_stall
// back to the sender; a byte is taken at an edge with i_valid high and
// o_stall low. Output channel: o_valid and the result fields, with i_stall
// from the receiver; a result is taken at an edge with o_valid high and
// i_stall low.
// Throughput is one byte per cycle while o_stall is low. Each byte updates the
// phase logic in the same cycle it is taken, and any result it causes is in
// the output register in the cycle after. Hunting bytes and the first six
// header bytes give no result; the seventh header byte gives the header
// report, each body byte gives one body result.
// o_stall rises only while a result is held and the receiver stalls, so a
// byte is still taken in the cycle that an old result is drained.
// Synchronous active-low reset returns to hunting with the skip count at
// zero, empties the output register and sets byte order to little endian.
// i_cfg_wr_en / i_cfg_wr_data write the big-endian flag; it is sampled
// when the seventh header byte is taken.
//
module sync_flag_length_deframer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_wr_data,
    input  logic               i_valid,
    input  logic [7:0]         i_in_byte,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_kind,
    output logic signed [7:0]  o_category,
    output logic signed [15:0] o_msg_id,
    output logic signed [31:0] o_total_length,
    output logic [15:0]        o_skipped_count,
    output logic [7:0]         o_body_byte,
    output logic               o_last
);
    import sfld_pkg::*;

`include "sync_flag_length_deframer_assert.svh"

    logic    accept;
    logic    res_valid;
    t_result res;
    t_result out_res;

    assign accept = i_valid && !o_stall;

    sfld_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (accept),
        .i_in_byte     (i_in_byte),
        .o_res_valid   (res_valid),
        .o_res         (res)
    );

    sfld_out_reg u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (res_valid),
        .i_res        (res),
        .i_stall      (i_stall),
        .o_full_stall (o_stall),
        .o_valid      (o_valid),
        .o_res        (out_res)
    );

    // unpack the result register
    assign o_kind          = out_res.kind;
    assign o_category      = out_res.category;
    assign o_msg_id        = out_res.msg_id;
    assign o_total_length  = out_res.total_length;
    assign o_skipped_count = out_res.skipped_count;
    assign o_body_byte     = out_res.body_byte;
    assign o_last          = out_res.last;

    // checks
    `SFLD_ASSERT_NOW(a_stall_only_when_full, o_stall, o_valid, "stall without held result")
    `SFLD_ASSERT_NOW(a_reject_is_last, o_valid && (o_kind == KIND_HDR_BAD), o_last, "reject not last")
    `SFLD_ASSERT_NOW(a_body_no_header, o_valid && (o_kind == KIND_BODY), (o_skipped_count == 16'd0) && (o_total_length == 32'sd0), "body carries header")
    `SFLD_ASSERT_NEXT(a_result_lands, res_valid, o_valid && (out_res == $past(res)), "result not registered")

endmodule
